FILE: hdl/bpdc_pkg.sv
// ----------------------------------------------------------------------------
// bpdc_pkg
// shared types and constants for the button press duration classifier
// ----------------------------------------------------------------------------
package bpdc_pkg;

    localparam int CfgWidth   = 16;
    localparam int IndexWidth = 2;
    localparam int EventWidth = 2;

    typedef logic [CfgWidth-1:0]   cfg_word_t;
    typedef logic [IndexWidth-1:0] cfg_index_t;

    // register indexes
    localparam cfg_index_t REG_DEBOUNCE  = 2'd0;
    localparam cfg_index_t REG_LONG      = 2'd1;
    localparam cfg_index_t REG_VERY_LONG = 2'd2;
    localparam cfg_index_t REG_HOLD      = 2'd3;

    // reset values of the thresholds
    localparam cfg_word_t DEBOUNCE_RESET  = 16'd20;
    localparam cfg_word_t LONG_RESET      = 16'd200;
    localparam cfg_word_t VERY_LONG_RESET = 16'd600;
    localparam cfg_word_t HOLD_RESET      = 16'd800;

    // event codes
    typedef enum logic [EventWidth-1:0] {
        EV_NONE      = 2'd0,
        EV_CLICK     = 2'd1,
        EV_LONG      = 2'd2,
        EV_VERY_LONG = 2'd3
    } event_t;

    // counter steps
    localparam int HOLD_STEP_BACK      = 5;
    localparam int VERY_LONG_STEP_BACK = 15;
    localparam int DEBOUNCE_JUMP       = 10;
    localparam int LONG_STEP           = 1;
    localparam logic [1:0] REPEAT_LIMIT = 2'd2;

    typedef struct packed {
        cfg_word_t debounce_ticks;
        cfg_word_t long_ticks;
        cfg_word_t very_long_ticks;
        cfg_word_t hold_ticks;
    } cfg_t;

endpackage

FILE: hdl/button_press_duration_classifier.sv
// ----------------------------------------------------------------------------
// button_press_duration_classifier
// debounced active-low button with click, long and very long press events
// ----------------------------------------------------------------------------
//  channel  | handshake                  | payload
//  ---------+----------------------------+------------------------
//  input    | in_valid / in_ready        | pin_level
//  output   | out_valid / out_ready      | event_code
//  config   | cfg_write_en (no wait)     | cfg_index, cfg_data
//
//  one word per cycle sustained unless the output stalls; a word passes the
//  input register, then the counter update into the result register
//  every word gives exactly one result word, event_code 0 when nothing happens
//  a stalled output holds the result; an empty input register takes a word
//  reset clears counters, click flag and valid bits; thresholds load defaults
// ----------------------------------------------------------------------------
module button_press_duration_classifier #(
    parameter int COUNT_WIDTH = 16
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic                  pin_level,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [1:0]            event_code,
    input  logic                  cfg_write_en,
    input  bpdc_pkg::cfg_index_t  cfg_index,
    input  bpdc_pkg::cfg_word_t   cfg_data
);
    import bpdc_pkg::*;

    cfg_t   cfg;
    event_t event_next;
    event_t event_reg;
    logic   s1_valid_reg, s1_pin_reg;
    logic   out_valid_reg;
    logic   out_free, load_out;

    assign out_free = !out_valid_reg || out_ready;
    assign load_out = s1_valid_reg && out_free;
    assign in_ready = !s1_valid_reg || out_free;

    bpdc_cfg u_cfg (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .cfg          (cfg)
    );

    bpdc_core #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .step       (load_out),
        .pin        (s1_pin_reg),
        .cfg        (cfg),
        .event_next (event_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
            begin
                s1_valid_reg <= in_valid;
            end
            if (out_free)
            begin
                out_valid_reg <= s1_valid_reg;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            s1_pin_reg <= pin_level;
        end
        if (load_out)
        begin
            event_reg <= event_next;
        end
    end

    assign out_valid  = out_valid_reg;
    assign event_code = event_reg;

`ifndef SYNTHESIS
    a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> (s1_valid_reg && out_valid_reg && !out_ready))
        else $error("input stalled while a stage is free");

    a_word_moves_on: assert property (@(posedge clk) disable iff (!rst_n)
        load_out |=> out_valid_reg)
        else $error("word lost between input and result register");

    a_click_on_release: assert property (@(posedge clk) disable iff (!rst_n)
        (load_out && event_next == EV_CLICK) |-> s1_pin_reg)
        else $error("click event while the button is pressed");
`endif

endmodule

FILE: hdl/bpdc_cfg.sv
// ----------------------------------------------------------------------------
// bpdc_cfg
// threshold register file, written by index
// ----------------------------------------------------------------------------
module bpdc_cfg (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_write_en,
    input  bpdc_pkg::cfg_index_t  cfg_index,
    input  bpdc_pkg::cfg_word_t   cfg_data,
    output bpdc_pkg::cfg_t        cfg
);
    import bpdc_pkg::*;

    cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.debounce_ticks  <= DEBOUNCE_RESET;
            cfg_reg.long_ticks      <= LONG_RESET;
            cfg_reg.very_long_ticks <= VERY_LONG_RESET;
            cfg_reg.hold_ticks      <= HOLD_RESET;
        end
        else if (cfg_write_en)
        begin
            unique case (cfg_index)
                REG_DEBOUNCE:  cfg_reg.debounce_ticks  <= cfg_data;
                REG_LONG:      cfg_reg.long_ticks      <= cfg_data;
                REG_VERY_LONG: cfg_reg.very_long_ticks <= cfg_data;
                REG_HOLD:      cfg_reg.hold_ticks      <= cfg_data;
                default:       cfg_reg                 <= cfg_reg;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

FILE: hdl/bpdc_core.sv
// ----------------------------------------------------------------------------
// bpdc_core
// press counter, repeat counter and click flag with their one-step update
// ----------------------------------------------------------------------------
module bpdc_core #(
    parameter int COUNT_WIDTH = 16
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             step,
    input  logic             pin,
    input  bpdc_pkg::cfg_t   cfg,
    output bpdc_pkg::event_t event_next
);
    import bpdc_pkg::*;

    localparam int CmpW = (COUNT_WIDTH > CfgWidth) ? COUNT_WIDTH : CfgWidth;

    localparam logic [CmpW-1:0] CountMax     = CmpW'({COUNT_WIDTH{1'b1}});
    localparam logic [CmpW:0]   CountMaxWide = (CmpW+1)'(CountMax);

    logic [COUNT_WIDTH-1:0] count_reg, count_next;
    logic [1:0]             repeats_reg, repeats_next;
    logic                   armed_reg, armed_next;

    logic [CmpW-1:0] count_ext, deb_ext, long_ext, vlong_ext, hold_ext;
    logic [CmpW-1:0] hold_back, vlong_back, climbed;
    logic [CmpW:0]   long_sum, deb_sum;
    logic [CmpW-1:0] long_sat, deb_sat;
    logic [1:0]      repeats_inc;

    assign count_ext = CmpW'(count_reg);
    assign deb_ext   = CmpW'(cfg.debounce_ticks);
    assign long_ext  = CmpW'(cfg.long_ticks);
    assign vlong_ext = CmpW'(cfg.very_long_ticks);
    assign hold_ext  = CmpW'(cfg.hold_ticks);

    assign hold_back  = (hold_ext > CmpW'(HOLD_STEP_BACK))
                        ? hold_ext - CmpW'(HOLD_STEP_BACK) : '0;
    assign vlong_back = (vlong_ext > CmpW'(VERY_LONG_STEP_BACK))
                        ? vlong_ext - CmpW'(VERY_LONG_STEP_BACK) : '0;

    assign long_sum = {1'b0, long_ext} + (CmpW+1)'(LONG_STEP);
    assign deb_sum  = {1'b0, deb_ext} + (CmpW+1)'(DEBOUNCE_JUMP);
    assign long_sat = (long_sum > CountMaxWide) ? CountMax : long_sum[CmpW-1:0];
    assign deb_sat  = (deb_sum > CountMaxWide) ? CountMax : deb_sum[CmpW-1:0];

    assign climbed = (count_ext < hold_ext && count_ext < CountMax)
                     ? count_ext + CmpW'(1) : count_ext;

    assign repeats_inc = repeats_reg + 2'd1;

    always_comb
    begin
        count_next   = count_reg;
        repeats_next = repeats_reg;
        armed_next   = armed_reg;
        event_next   = EV_NONE;
        if (!pin)
        begin
            priority if (count_ext == hold_ext)
            begin
                count_next = hold_back[COUNT_WIDTH-1:0];
            end
            else if (count_ext == vlong_ext)
            begin
                event_next = EV_VERY_LONG;
                if (repeats_inc == REPEAT_LIMIT)
                begin
                    count_next   = hold_ext[COUNT_WIDTH-1:0];
                    repeats_next = '0;
                end
                else
                begin
                    count_next   = vlong_back[COUNT_WIDTH-1:0];
                    repeats_next = repeats_inc;
                end
            end
            else if (count_ext == long_ext)
            begin
                count_next = long_sat[COUNT_WIDTH-1:0];
                event_next = EV_LONG;
            end
            else
            begin
                priority if (climbed == deb_ext)
                begin
                    count_next = deb_sat[COUNT_WIDTH-1:0];
                    armed_next = 1'b1;
                end
                else if (climbed >= long_ext)
                begin
                    count_next = climbed[COUNT_WIDTH-1:0];
                    armed_next = 1'b0;
                end
                else
                begin
                    count_next = climbed[COUNT_WIDTH-1:0];
                end
            end
        end
        else
        begin
            count_next = '0;
            if (armed_reg)
            begin
                event_next = EV_CLICK;
                armed_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg   <= '0;
            repeats_reg <= '0;
            armed_reg   <= 1'b0;
        end
        else if (step)
        begin
            count_reg   <= count_next;
            repeats_reg <= repeats_next;
            armed_reg   <= armed_next;
        end
    end

endmodule

FILE: verif/button_press_duration_classifier_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// button_press_duration_classifier_tb
// drives sampled pin words through the classifier and checks each event word
// against a cycle-free predictor of the press counter, repeat counter and
// click flag; directed presses, threshold extremes and random press, release
// and bounce traffic under several threshold sets, with random gaps on both
// channels and one long output stall
// ----------------------------------------------------------------------------
module button_press_duration_classifier_tb;

    import bpdc_pkg::*;

    localparam int CountWidth = 16;
    localparam int CountMax   = (1 << CountWidth) - 1;
    localparam int CycleLimit = 200000;
    localparam int StallCycles = 80;

    class press_scoreboard;
        cfg_t                  thresholds;
        logic [CountWidth-1:0] press_count;
        logic [1:0]            repeats;
        bit                    click_armed;
        event_t                expected_q[$];
        int                    errors;
        int                    clicks;
        int                    longs;
        int                    very_longs;

        function new();
            thresholds  = '{DEBOUNCE_RESET, LONG_RESET, VERY_LONG_RESET, HOLD_RESET};
            press_count = '0;
            repeats     = '0;
            click_armed = 1'b0;
            errors      = 0;
            clicks      = 0;
            longs       = 0;
            very_longs  = 0;
        endfunction

        function logic [CountWidth-1:0] sat_down(int a, int b);
            return (a > b) ? CountWidth'(a - b) : '0;
        endfunction

        function logic [CountWidth-1:0] sat_up(int a, int b);
            return (a + b > CountMax) ? CountWidth'(CountMax) : CountWidth'(a + b);
        endfunction

        function void load_thresholds(cfg_t c);
            thresholds = c;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        // accepted pin word: advance the counters and queue the event it causes
        function void note_word(logic pin);
            event_t ev;
            ev = EV_NONE;
            if (!pin)
            begin
                if (press_count == thresholds.hold_ticks)
                begin
                    press_count = sat_down(int'(thresholds.hold_ticks), HOLD_STEP_BACK);
                end
                else if (press_count == thresholds.very_long_ticks)
                begin
                    press_count = sat_down(int'(thresholds.very_long_ticks),
                                           VERY_LONG_STEP_BACK);
                    repeats = repeats + 2'd1;
                    if (repeats == REPEAT_LIMIT)
                    begin
                        press_count = thresholds.hold_ticks;
                        repeats = '0;
                    end
                    ev = EV_VERY_LONG;
                end
                else if (press_count == thresholds.long_ticks)
                begin
                    press_count = sat_up(int'(thresholds.long_ticks), LONG_STEP);
                    ev = EV_LONG;
                end
                else
                begin
                    if (press_count < thresholds.hold_ticks &&
                        press_count != CountWidth'(CountMax))
                        press_count = press_count + 1'b1;
                    if (press_count == thresholds.debounce_ticks)
                    begin
                        press_count = sat_up(int'(thresholds.debounce_ticks), DEBOUNCE_JUMP);
                        click_armed = 1'b1;
                    end
                    else if (press_count >= thresholds.long_ticks)
                    begin
                        click_armed = 1'b0;
                    end
                end
            end
            else
            begin
                press_count = '0;
                if (click_armed)
                begin
                    ev = EV_CLICK;
                    click_armed = 1'b0;
                end
            end
            case (ev)
                EV_CLICK:     clicks++;
                EV_LONG:      longs++;
                EV_VERY_LONG: very_longs++;
                default:      ;
            endcase
            expected_q.push_back(ev);
        endfunction

        function void check_word(logic [1:0] got);
            event_t want;
            if (expected_q.size() == 0)
            begin
                $error("event_code: no word expected, actual %0d", got);
                errors++;
            end
            else
            begin
                want = expected_q.pop_front();
                if (got !== want)
                begin
                    $error("event_code: expected %0d, actual %0d", want, got);
                    errors++;
                end
            end
        endfunction
    endclass

    logic       clk;
    logic       rst_n;
    logic       in_valid;
    logic       in_ready;
    logic       pin_level;
    logic       out_valid;
    logic       out_ready;
    logic [1:0] event_code;
    logic       cfg_write_en;
    cfg_index_t cfg_index;
    cfg_word_t  cfg_data;

    press_scoreboard sb = new();

    bit steady;
    bit stall_req;
    int stall_left;
    int words_sent;
    int settings_run;
    int cycle_count;

    button_press_duration_classifier #(
        .COUNT_WIDTH (CountWidth)
    ) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .pin_level    (pin_level),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .event_code   (event_code),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    always @(posedge clk)
    begin
        if (rst_n && in_valid && in_ready)
            sb.note_word(pin_level);
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            sb.check_word(event_code);
    end

    // receiver side: random back-pressure plus one long hold-off on request
    initial
    begin
        stall_left = 0;
        out_ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (stall_req)
            begin
                stall_req = 1'b0;
                stall_left = StallCycles;
            end
            if (stall_left > 0)
            begin
                stall_left--;
                out_ready <= 1'b0;
            end
            else
            begin
                out_ready <= steady ? 1'b1 : ($urandom_range(99) >= 7);
            end
        end
    end

    initial
    begin
        cycle_count = 0;
        while (cycle_count < CycleLimit)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("[FAIL] regression broken");
        $finish;
    end

    task automatic send_word(input logic pin);
        while (!steady && $urandom_range(99) < 7)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid  <= 1'b1;
        pin_level <= pin;
        do @(posedge clk); while (!in_ready);
        words_sent++;
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.pending() > 0) @(posedge clk);
    endtask

    task automatic write_thresholds(input cfg_t c);
        cfg_write_en <= 1'b1;
        cfg_index    <= REG_DEBOUNCE;
        cfg_data     <= c.debounce_ticks;
        @(posedge clk);
        cfg_index    <= REG_LONG;
        cfg_data     <= c.long_ticks;
        @(posedge clk);
        cfg_index    <= REG_VERY_LONG;
        cfg_data     <= c.very_long_ticks;
        @(posedge clk);
        cfg_index    <= REG_HOLD;
        cfg_data     <= c.hold_ticks;
        @(posedge clk);
        cfg_write_en <= 1'b0;
        sb.load_thresholds(c);
        settings_run++;
    endtask

    // presses of random length with releases, mixed with bounce noise
    task automatic run_presses(input int budget, input int max_hold);
        int start;
        start = words_sent;
        while (words_sent - start < budget)
        begin
            if ($urandom_range(99) < 15)
            begin
                repeat ($urandom_range(1, 6)) send_word(1'($urandom_range(1)));
            end
            else
            begin
                repeat ($urandom_range(1, max_hold)) send_word(1'b0);
                repeat ($urandom_range(1, 3)) send_word(1'b1);
            end
        end
        drain_results();
    endtask

    initial
    begin
        cfg_t c;
        int   mode;
        steady       = 1'b0;
        stall_req    = 1'b0;
        words_sent   = 0;
        settings_run = 1;
        rst_n        <= 1'b0;
        in_valid     <= 1'b0;
        pin_level    <= 1'b1;
        cfg_write_en <= 1'b0;
        cfg_index    <= REG_DEBOUNCE;
        cfg_data     <= '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset thresholds
        run_presses(60, 40);

        // bounce, then one hold through long, both very long branches and hold
        write_thresholds('{16'd2, 16'd14, 16'd16, 16'd17});
        send_word(1'b1);
        send_word(1'b0);
        send_word(1'b1);
        repeat (15) send_word(1'b0);
        send_word(1'b1);
        drain_results();

        // step-back clamps at zero, jump to hold, debounce jump and long step clamp at top
        write_thresholds('{16'd65526, 16'd65535, 16'd1, 16'd65530});
        repeat (10) send_word(1'b0);
        send_word(1'b1);
        drain_results();

        write_thresholds('{16'd1, 16'd1, 16'd1, 16'd1});
        run_presses(40, 8);
        write_thresholds('{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF});
        run_presses(40, 30);

        for (int p = 0; p < 8; p++)
        begin
            mode = p % 3;
            c.debounce_ticks  = CfgWidth'($urandom_range(1, 5));
            c.long_ticks      = c.debounce_ticks + CfgWidth'($urandom_range(8, 20));
            c.very_long_ticks = c.long_ticks + CfgWidth'($urandom_range(1, 12));
            c.hold_ticks      = c.very_long_ticks + CfgWidth'($urandom_range(1, 12));
            if (mode == 1)
                c = '{CfgWidth'($urandom_range(1, 40)), CfgWidth'($urandom_range(1, 40)),
                      CfgWidth'($urandom_range(1, 40)), CfgWidth'($urandom_range(1, 40))};
            else if (mode == 2)
                c.very_long_ticks = CfgWidth'($urandom_range(CountMax));
            write_thresholds(c);
            steady = (p == 3);
            if (p == 5)
                stall_req = 1'b1;
            run_presses(75, 70);
        end
        steady = 1'b0;

        drain_results();
        repeat (8) @(posedge clk);
        if (sb.pending() > 0)
        begin
            $error("event_code: %0d expected words never arrived", sb.pending());
            sb.errors++;
        end
        $display("run covered %0d pin words over %0d threshold sets", words_sent,
                 settings_run);
        $display("events seen: %0d click, %0d long, %0d very long", sb.clicks, sb.longs,
                 sb.very_longs);
        if (sb.errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
